[hw/rtl/rdt_pkg.sv]
// ----------------------------------------------------------------------------
// rdt_pkg
// Shared types and constants of the reliable datagram tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package rdt_pkg;

    localparam int PENDING_DEPTH_DEF = 16;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [7:0]  RESEND_PERIOD_RST = 8'd50;
    localparam logic [5:0]  MAX_ATTEMPTS_RST  = 6'd40;
    localparam logic [15:0] REPLAY_WINDOW_RST = 16'd300;
    localparam logic [7:0]  SWEEP_TIMER_RST   = 8'd50;

    localparam logic [1:0] CFG_RESEND_PERIOD = 2'd0;
    localparam logic [1:0] CFG_MAX_ATTEMPTS  = 2'd1;
    localparam logic [1:0] CFG_REPLAY_WINDOW = 2'd2;

    localparam logic [1:0] ACT_PACKET = 2'd0;
    localparam logic [1:0] ACT_SEND   = 2'd1;
    localparam logic [1:0] ACT_TICK   = 2'd2;

    localparam logic [2:0] KIND_NONE     = 3'd0;
    localparam logic [2:0] KIND_FOUND    = 3'd1;
    localparam logic [2:0] KIND_ECHO     = 3'd2;
    localparam logic [2:0] KIND_DELIVER  = 3'd3;
    localparam logic [2:0] KIND_RELIABLE = 3'd4;
    localparam logic [2:0] KIND_RESEND   = 3'd5;
    localparam logic [2:0] KIND_NOT_OWN  = 3'd6;
    localparam logic [2:0] KIND_FULL     = 3'd7;

    typedef struct packed {
        logic [1:0]         action;
        logic               is_discover;
        logic               is_possess;
        logic               has_counter;
        logic signed [31:0] counter;
        logic               has_f;
        logic [30:0]        f_value;
        logic               has_e;
        logic [30:0]        e_value;
        logic [31:0]        src_addr;
        logic [15:0]        src_port;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [30:0] msg_id;
        logic [30:0] seq_out;
        logic [31:0] dest_addr;
        logic [15:0] dest_port;
        logic        last;
    } out_item_t;

    typedef enum logic [2:0] {
        OP_FOUND  = 3'd0,
        OP_DROP   = 3'd1,
        OP_PACKET = 3'd2,
        OP_SEND   = 3'd3,
        OP_TICK   = 3'd4
    } op_t;

    typedef struct packed {
        op_t      op;
        in_item_t item;
    } work_t;

endpackage

`default_nettype wire

[hw/rtl/rdt_if.sv]
// ----------------------------------------------------------------------------
// rdt interfaces
// Valid/ready channels: request beats, result beats and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface rdt_req_if;
    logic              valid;
    logic              ready;
    rdt_pkg::in_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rdt_rsp_if;
    logic               valid;
    logic               ready;
    rdt_pkg::out_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rdt_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/rdt_front.sv]
// ----------------------------------------------------------------------------
// rdt_front
// Accepts request beats, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rdt_front (
    input  wire logic     clk,
    input  wire logic     rst_n,
    rdt_req_if.sink       req,
    output rdt_pkg::work_t q_head,
    output logic          q_valid,
    input  wire logic     q_pop,
    output logic          q_full
);

    localparam int QD = rdt_pkg::QUEUE_DEPTH;
    localparam int QW = (QD > 1) ? $clog2(QD) : 1;
    localparam int LW = $clog2(QD + 1);

    rdt_pkg::work_t   mem_reg [QD];
    logic [QW-1:0]    rd_ptr_reg, wr_ptr_reg;
    logic [LW-1:0]    level_reg;
    rdt_pkg::op_t     op;
    logic             push;

    always_comb
    begin
        unique case (req.payload.action)
            rdt_pkg::ACT_PACKET:
            begin
                if (req.payload.is_discover)
                    op = rdt_pkg::OP_FOUND;
                else if (req.payload.has_counter)
                    op = rdt_pkg::OP_PACKET;
                else
                    op = rdt_pkg::OP_DROP;
            end
            rdt_pkg::ACT_SEND: op = rdt_pkg::OP_SEND;
            rdt_pkg::ACT_TICK: op = rdt_pkg::OP_TICK;
            default:           op = rdt_pkg::OP_DROP;
        endcase
    end

    assign q_full    = (level_reg == LW'(QD));
    assign req.ready = !q_full;
    assign push      = req.valid && req.ready;
    assign q_valid   = (level_reg != '0);
    assign q_head    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg].op   <= op;
            mem_reg[wr_ptr_reg].item <= req.payload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QW'(QD - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (q_pop)
                rd_ptr_reg <= (rd_ptr_reg == QW'(QD - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !q_pop)
                level_reg <= level_reg + 1'b1;
            else if (!push && q_pop)
                level_reg <= level_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/rdt_back.sv]
// ----------------------------------------------------------------------------
// rdt_back
// Session state, pending table walks and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rdt_back #(
    parameter int PENDING_DEPTH = rdt_pkg::PENDING_DEPTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    rdt_cfg_if.sink             cfg,
    rdt_rsp_if.source           rsp,
    input  wire rdt_pkg::work_t q_head,
    input  wire logic           q_valid,
    output logic                q_pop
);

    localparam int D     = PENDING_DEPTH;
    localparam int IDX_W = (D > 1) ? $clog2(D) : 1;
    localparam int CNT_W = $clog2(D + 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_RUN    = 5'b00010,
        ST_FINAL  = 5'b00100,
        ST_SEARCH = 5'b01000,
        ST_SWEEP  = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    rdt_pkg::work_t     work_reg, work_next;
    logic [CNT_W-1:0]   k_reg, k_next, count_reg, count_next, k_new;
    logic [31:0]        read_seq_reg, read_seq_next;
    logic [30:0]        write_seq_reg, write_seq_next, ws_base;
    logic [31:0]        last_f_reg, last_f_next, lf_eff;
    logic [30:0]        next_id_reg, next_id_next;
    logic [31:0]        owner_addr_reg, owner_addr_next;
    logic [15:0]        owner_port_reg, owner_port_next;
    logic [7:0]         timer_reg, timer_next;
    logic [7:0]         period_reg;
    logic [5:0]         max_reg;
    logic [15:0]        window_reg;

    logic [30:0]        id_reg [D];
    logic [5:0]         tries_reg [D];
    logic [IDX_W-1:0]   k_idx;
    logic [5:0]         tries_new;

    logic               out_valid_reg;
    rdt_pkg::out_item_t out_data_reg, em;
    logic               emit, slot_free;
    logic               do_rsend, do_remove, pend_wr, pend_inc;
    logic               cnt_reset, stale, rebind;
    logic [32:0]        diff;

    assign k_idx     = k_reg[IDX_W-1:0];
    assign tries_new = tries_reg[k_idx] + 6'd1;
    assign slot_free = !out_valid_reg || rsp.ready;
    assign cnt_reset = (work_reg.item.counter == 32'hFFFF_FFFF);
    assign diff      = {read_seq_reg[31], read_seq_reg}
                     - {work_reg.item.counter[31], work_reg.item.counter};
    assign stale     = !cnt_reset
                     && ($signed(work_reg.item.counter) < $signed(read_seq_reg))
                     && (diff < {17'd0, window_reg});
    assign rebind    = work_reg.item.is_possess
                     && ((owner_addr_reg != work_reg.item.src_addr)
                     ||  (owner_port_reg != work_reg.item.src_port));
    assign lf_eff    = rebind ? 32'd0 : last_f_reg;
    assign ws_base   = cnt_reset ? 31'd0 : write_seq_reg;

    always_comb
    begin
        state_next      = state_reg;
        work_next       = work_reg;
        k_next          = k_reg;
        k_new           = k_reg;
        count_next      = count_reg;
        read_seq_next   = read_seq_reg;
        write_seq_next  = write_seq_reg;
        last_f_next     = last_f_reg;
        next_id_next    = next_id_reg;
        owner_addr_next = owner_addr_reg;
        owner_port_next = owner_port_reg;
        timer_next      = timer_reg;
        emit            = 1'b0;
        em              = '0;
        do_rsend        = 1'b0;
        do_remove       = 1'b0;
        pend_wr         = 1'b0;
        pend_inc        = 1'b0;
        q_pop           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    work_next  = q_head;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                    unique case (work_reg.op)
                        rdt_pkg::OP_FOUND:
                        begin
                            emit         = 1'b1;
                            em.kind      = rdt_pkg::KIND_FOUND;
                            em.dest_addr = work_reg.item.src_addr;
                            em.dest_port = work_reg.item.src_port;
                            em.last      = 1'b1;
                        end
                        rdt_pkg::OP_SEND: do_rsend = 1'b1;
                        rdt_pkg::OP_TICK:
                        begin
                            if (timer_reg <= 8'd1)
                            begin
                                timer_next = period_reg;
                                if (count_reg == '0)
                                begin
                                    emit    = 1'b1;
                                    em.last = 1'b1;
                                end
                                else
                                begin
                                    k_next     = '0;
                                    state_next = ST_SWEEP;
                                end
                            end
                            else
                            begin
                                timer_next = timer_reg - 8'd1;
                                emit       = 1'b1;
                                em.last    = 1'b1;
                            end
                        end
                        rdt_pkg::OP_PACKET:
                        begin
                            if (stale)
                            begin
                                emit    = 1'b1;
                                em.last = 1'b1;
                            end
                            else
                            begin
                                read_seq_next  = cnt_reset ? 32'd0 : work_reg.item.counter;
                                write_seq_next = ws_base;
                                if (work_reg.item.has_f)
                                begin
                                    emit           = 1'b1;
                                    em.kind        = rdt_pkg::KIND_ECHO;
                                    em.seq_out     = ws_base;
                                    em.dest_addr   = work_reg.item.src_addr;
                                    em.dest_port   = work_reg.item.src_port;
                                    write_seq_next = ws_base + 31'd1;
                                    if (work_reg.item.is_possess)
                                        count_next = '0;
                                    if (rebind)
                                    begin
                                        owner_addr_next = work_reg.item.src_addr;
                                        owner_port_next = work_reg.item.src_port;
                                        next_id_next    = '0;
                                    end
                                    if ({1'b0, work_reg.item.f_value} <= lf_eff)
                                    begin
                                        em.last     = 1'b1;
                                        last_f_next = lf_eff;
                                    end
                                    else
                                    begin
                                        last_f_next = {1'b0, work_reg.item.f_value};
                                        state_next  = ST_FINAL;
                                    end
                                end
                                else if (work_reg.item.has_e)
                                begin
                                    k_next     = '0;
                                    state_next = ST_SEARCH;
                                end
                                else
                                begin
                                    state_next = ST_FINAL;
                                end
                            end
                        end
                        default:
                        begin
                            emit    = 1'b1;
                            em.last = 1'b1;
                        end
                    endcase
                end
            end
            ST_FINAL:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                    if (work_reg.item.is_possess)
                        do_rsend = 1'b1;
                    else
                    begin
                        emit         = 1'b1;
                        em.kind      = rdt_pkg::KIND_DELIVER;
                        em.dest_addr = work_reg.item.src_addr;
                        em.dest_port = work_reg.item.src_port;
                        em.last      = 1'b1;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (slot_free)
                begin
                    if (k_reg == count_reg)
                    begin
                        emit       = 1'b1;
                        em.last    = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (id_reg[k_idx] == work_reg.item.e_value)
                    begin
                        do_remove  = 1'b1;
                        count_next = count_reg - 1'b1;
                        emit       = 1'b1;
                        em.last    = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            ST_SWEEP:
            begin
                if (slot_free)
                begin
                    emit           = 1'b1;
                    em.kind        = rdt_pkg::KIND_RESEND;
                    em.msg_id      = id_reg[k_idx];
                    em.seq_out     = write_seq_reg;
                    em.dest_addr   = owner_addr_reg;
                    em.dest_port   = owner_port_reg;
                    write_seq_next = write_seq_reg + 31'd1;
                    if (tries_new >= max_reg)
                    begin
                        do_remove  = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                    else
                    begin
                        pend_inc = 1'b1;
                        k_new    = k_reg + 1'b1;
                    end
                    k_next = k_new;
                    if (k_new >= count_next)
                    begin
                        em.last    = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (do_rsend)
        begin
            emit    = 1'b1;
            em.last = 1'b1;
            if (owner_port_reg == '0)
                em.kind = rdt_pkg::KIND_NOT_OWN;
            else if (count_reg == CNT_W'(D))
                em.kind = rdt_pkg::KIND_FULL;
            else
            begin
                pend_wr        = 1'b1;
                next_id_next   = next_id_reg + 31'd1;
                count_next     = count_reg + 1'b1;
                write_seq_next = write_seq_reg + 31'd1;
                em.kind        = rdt_pkg::KIND_RELIABLE;
                em.msg_id      = next_id_reg + 31'd1;
                em.seq_out     = write_seq_reg;
                em.dest_addr   = owner_addr_reg;
                em.dest_port   = owner_port_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_remove)
        begin
            for (int i = 0; i < D - 1; i++)
            begin
                if (CNT_W'(i) >= k_reg)
                begin
                    id_reg[i]    <= id_reg[i + 1];
                    tries_reg[i] <= tries_reg[i + 1];
                end
            end
        end
        if (pend_inc)
            tries_reg[k_idx] <= tries_new;
        if (pend_wr)
        begin
            id_reg[count_reg[IDX_W-1:0]]    <= next_id_reg + 31'd1;
            tries_reg[count_reg[IDX_W-1:0]] <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        k_reg    <= k_next;
        if (emit)
            out_data_reg <= em;
    end

    assign cfg.ready   = 1'b1;
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            read_seq_reg   <= '0;
            write_seq_reg  <= '0;
            last_f_reg     <= '0;
            next_id_reg    <= '0;
            owner_addr_reg <= '0;
            owner_port_reg <= '0;
            timer_reg      <= rdt_pkg::SWEEP_TIMER_RST;
            period_reg     <= rdt_pkg::RESEND_PERIOD_RST;
            max_reg        <= rdt_pkg::MAX_ATTEMPTS_RST;
            window_reg     <= rdt_pkg::REPLAY_WINDOW_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            read_seq_reg   <= read_seq_next;
            write_seq_reg  <= write_seq_next;
            last_f_reg     <= last_f_next;
            next_id_reg    <= next_id_next;
            owner_addr_reg <= owner_addr_next;
            owner_port_reg <= owner_port_next;
            timer_reg      <= timer_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    rdt_pkg::CFG_RESEND_PERIOD: period_reg <= cfg.data[7:0];
                    rdt_pkg::CFG_MAX_ATTEMPTS:  max_reg    <= cfg.data[5:0];
                    rdt_pkg::CFG_REPLAY_WINDOW: window_reg <= cfg.data;
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/reliable_datagram_tracker.sv]
// ----------------------------------------------------------------------------
// reliable_datagram_tracker
// One-peer reliable datagram session tracker: replay check, echo, ownership,
// pending table with ack retirement and periodic resends.
//
//   channel | dir | beat
//   req     | in  | packet header, send request or tick
//   rsp     | out | one result; last marks the final one of a request
//   cfg     | in  | register write (index, data), always ready
//
// In the back end a request is popped in IDLE and handled in RUN; a packet
// that is delivered or turns into a reliable send then passes FINAL, an ack
// search walks the entries in SEARCH and a resend sweep walks them in SWEEP.
// A two-beat queue sits in front, a result register behind; a stalled rsp
// holds the back end while the front keeps filling its queue.
// Reset clears the pending table at once (fill count); no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module reliable_datagram_tracker #(
    parameter int PENDING_DEPTH = rdt_pkg::PENDING_DEPTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    rdt_req_if.sink   req,
    rdt_rsp_if.source rsp,
    rdt_cfg_if.sink   cfg
);

    rdt_pkg::work_t q_head;
    logic           q_valid;
    logic           q_pop;
    logic           q_full;

    rdt_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_head  (q_head),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_full  (q_full)
    );

    rdt_back #(
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .rsp     (rsp),
        .q_head  (q_head),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    a_queue_hold: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && !q_pop |=> q_valid)
        else $error("queued beat lost");

    a_queue_stable: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && !q_pop |=> $stable(q_head))
        else $error("queued beat changed before pop");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        q_full && !q_pop |=> !req.ready)
        else $error("queue full but request taken");

endmodule

`default_nettype wire
